// File: rtl/cbad_pkg.sv
// cbad_pkg: shared constants, codes and types of the console bus address decoder.
// Used by every module under rtl/ but cbad_ram; depends on nothing.
`timescale 1ns / 1ps

package cbad_pkg;

   // store depths and index widths
   localparam int unsigned WRAM_DEPTH = 131072;
   localparam int unsigned IO_DEPTH   = 16384;
   localparam int unsigned ROM_DEPTH  = 1048576;
   localparam int unsigned WRAM_AW    = $clog2(WRAM_DEPTH);
   localparam int unsigned IO_AW      = $clog2(IO_DEPTH);
   localparam int unsigned ROM_AW     = $clog2(ROM_DEPTH);

   localparam logic [WRAM_AW-1:0] CLR_LAST  = WRAM_AW'(WRAM_DEPTH - 1);
   localparam logic [23:0]        ROM_LIMIT = 24'(ROM_DEPTH);

   // memory map
   localparam logic [7:0]  BANK_WRAM_LO = 8'h7E;
   localparam logic [7:0]  BANK_WRAM_HI = 8'h7F;
   localparam logic [7:0]  BANK_LOW_END = 8'h3F;
   localparam logic [7:0]  BANK_HI_BEG  = 8'h80;
   localparam logic [7:0]  BANK_HI_END  = 8'hBF;
   localparam logic [7:0]  BANK_ROM_END = 8'h7D;
   localparam logic [15:0] OFF_MIRROR_END = 16'h1FFF;
   localparam logic [15:0] OFF_IO_BEG     = 16'h2000;
   localparam logic [15:0] OFF_IO_END     = 16'h5FFF;
   localparam logic [15:0] OFF_ROM_BEG    = 16'h8000;
   localparam logic [7:0]  OPEN_BUS       = 8'hFF;

   // request codes
   localparam logic [2:0] REQ_READ8   = 3'd0;
   localparam logic [2:0] REQ_WRITE8  = 3'd1;
   localparam logic [2:0] REQ_READ16  = 3'd2;
   localparam logic [2:0] REQ_WRITE16 = 3'd3;
   localparam logic [2:0] REQ_READ24  = 3'd4;
   localparam logic [2:0] REQ_LOAD    = 3'd5;

   // register indexes
   localparam logic CSR_CART_PRESENT = 1'b0;
   localparam logic CSR_ROM_SIZE     = 1'b1;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_NONE,
      OP_READ,
      OP_WRITE,
      OP_LOAD
   } op_kind_type;

   typedef enum logic [1:0] {
      SRC_FF,
      SRC_WRAM,
      SRC_IO,
      SRC_ROM
   } src_type;

   typedef struct packed {
      op_kind_type kind;
      logic [1:0]  last_lane;
      logic [23:0] address;
      logic [15:0] data;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic        cart_present;
      logic [20:0] rom_len;
   } cfg_type;

endpackage

// File: rtl/console_bus_address_decoder.sv
// console_bus_address_decoder: top level; registers, front, queue and back.
// Depends on cbad_pkg, cbad_front, cbad_queue and cbad_back.
//
//   channel   ports                                   beat taken when
//   request   start busy req_type req_address         start && !busy
//             req_write_data
//   response  rsp_valid rsp_read_data                 rsp_valid (one cycle)
//   csr       csr_write_enable csr_index              csr_write_enable
//             csr_write_data
//
// The back end does one byte per cycle on single-port RAMs outside the clearing
// pass: read16 and write16 have two bytes, read24 three and the other codes one.
// An item is written into the queue at its request beat, then passes through
// the issue, capture and response registers to the ports.
// After reset a clearing pass over every work RAM entry zeroes work RAM and I/O;
// busy stays high during it while csr writes are taken.
// busy also rises when the two-entry queue is full; the receiver cannot stall.
`timescale 1ns / 1ps

module console_bus_address_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [23:0] req_address,
   input  logic [15:0] req_write_data,
   output logic        rsp_valid,
   output logic [23:0] rsp_read_data,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [20:0] csr_write_data
);

   cbad_pkg::cfg_type          cfg_ff, cfg_in;
   cbad_pkg::queue_status_type q_status;
   cbad_pkg::item_type         push_item, head;
   logic                       push, pop, clearing;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            cbad_pkg::CSR_CART_PRESENT: cfg_in.cart_present = csr_write_data[0];
            cbad_pkg::CSR_ROM_SIZE:     cfg_in.rom_len      = csr_write_data;
            default:                    cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cbad_front u_front (
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .clearing       (clearing),
      .q_status       (q_status),
      .push           (push),
      .item           (push_item)
   );

   cbad_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   cbad_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .head          (head),
      .q_status      (q_status),
      .pop           (pop),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_read_data (rsp_read_data)
   );

`ifndef SYNTHESIS
   // nothing can be in flight while the RAMs are being cleared
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_valid)
      else $error("response beat during clearing pass");

   a_no_push_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !push)
      else $error("request taken during clearing pass");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("back end popped an empty queue");

   a_rsp_follows_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(clearing, 1))
      else $error("response beat right after clearing pass");
`endif

endmodule

// File: rtl/cbad_ram.sv
// cbad_ram: generic single-port RAM, one write or read per cycle, registered read.
// Stand-alone; used for work RAM, I/O registers and ROM.
`timescale 1ns / 1ps

module cbad_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/cbad_front.sv
// cbad_front: accepts requests and classifies them into queue items.
// Depends on cbad_pkg.
`timescale 1ns / 1ps

module cbad_front (
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_type,
   input  logic [23:0]               req_address,
   input  logic [15:0]               req_write_data,
   input  logic                      clearing,
   input  cbad_pkg::queue_status_type q_status,
   output logic                      push,
   output cbad_pkg::item_type        item
);

   always_comb begin
      busy = clearing || q_status.full;
      push = start && !busy;

      item.address = req_address;
      item.data    = req_write_data;
      unique case (req_type)
         cbad_pkg::REQ_READ8: begin
            item.kind      = cbad_pkg::OP_READ;
            item.last_lane = 2'd0;
         end
         cbad_pkg::REQ_WRITE8: begin
            item.kind      = cbad_pkg::OP_WRITE;
            item.last_lane = 2'd0;
         end
         cbad_pkg::REQ_READ16: begin
            item.kind      = cbad_pkg::OP_READ;
            item.last_lane = 2'd1;
         end
         cbad_pkg::REQ_WRITE16: begin
            item.kind      = cbad_pkg::OP_WRITE;
            item.last_lane = 2'd1;
         end
         cbad_pkg::REQ_READ24: begin
            item.kind      = cbad_pkg::OP_READ;
            item.last_lane = 2'd2;
         end
         cbad_pkg::REQ_LOAD: begin
            item.kind      = cbad_pkg::OP_LOAD;
            item.last_lane = 2'd0;
         end
         default: begin
            item.kind      = cbad_pkg::OP_NONE;
            item.last_lane = 2'd0;
         end
      endcase
   end

endmodule

// File: rtl/cbad_queue.sv
// cbad_queue: short in-order queue of classified items between front and back.
// Depends on cbad_pkg.
`timescale 1ns / 1ps

module cbad_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  cbad_pkg::item_type         push_item,
   input  logic                       pop,
   output cbad_pkg::item_type         head,
   output cbad_pkg::queue_status_type status
);

   cbad_pkg::item_type                entry_ff [cbad_pkg::QUEUE_DEPTH];
   logic [cbad_pkg::QUEUE_PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [cbad_pkg::QUEUE_PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [cbad_pkg::QUEUE_CW-1:0]     count_ff, count_in;

   always_comb begin
      status.empty = (count_ff == '0);
      status.full  = (count_ff == cbad_pkg::QUEUE_CW'(cbad_pkg::QUEUE_DEPTH));
      head         = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == cbad_pkg::QUEUE_PW'(cbad_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == cbad_pkg::QUEUE_PW'(cbad_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/cbad_back.sv
// cbad_back: runs queued items one byte per cycle against work RAM, I/O and ROM
// unless clearing, assembles read results and clears work RAM and I/O after reset.
// Depends on cbad_pkg and cbad_ram.
`timescale 1ns / 1ps

module cbad_back (
   input  logic                       clock,
   input  logic                       reset,
   input  cbad_pkg::cfg_type          cfg,
   input  cbad_pkg::item_type         head,
   input  cbad_pkg::queue_status_type q_status,
   output logic                       pop,
   output logic                       clearing,
   output logic                       rsp_valid,
   output logic [23:0]                rsp_read_data
);

   typedef struct packed {
      logic              valid;
      cbad_pkg::src_type src;
      logic [1:0]        lane;
      logic              last;
      logic              is_read;
   } cap_type;

   // clearing pass
   logic                         clr_ff, clr_in;
   logic [cbad_pkg::WRAM_AW-1:0] clr_cnt_ff, clr_cnt_in;

   // issue stage
   logic               act_ff, act_in;
   cbad_pkg::item_type cur_ff, cur_in;
   logic [1:0]         lane_ff, lane_in;
   logic               last_issue;

   // capture stage and output
   cap_type     cap_ff, cap_in;
   logic [23:0] acc_ff, acc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;

   // decode of the current byte address
   logic [7:0]                   bank;
   logic [15:0]                  off;
   logic [15:0]                  io_sub;
   logic                         low_banks;
   cbad_pkg::src_type            region;
   logic [cbad_pkg::WRAM_AW-1:0] wram_idx;
   logic [cbad_pkg::IO_AW-1:0]   io_idx;
   logic [21:0]                  rom_idx;
   logic                         rom_ok;

   // memory ports
   logic                         wram_we, io_we, rom_we;
   logic [cbad_pkg::WRAM_AW-1:0] wram_port_idx;
   logic [cbad_pkg::IO_AW-1:0]   io_addr;
   logic [cbad_pkg::ROM_AW-1:0]  rom_port_idx;
   logic [7:0]                   wram_wdata, io_wdata;
   logic [7:0]                   wram_rdata, io_rdata, rom_rdata;
   logic [7:0]                   rd_byte;

   always_comb begin
      bank      = cur_ff.address[23:16];
      off       = cur_ff.address[15:0];
      io_sub    = off - cbad_pkg::OFF_IO_BEG;
      low_banks = (bank <= cbad_pkg::BANK_LOW_END) ||
                  (bank >= cbad_pkg::BANK_HI_BEG && bank <= cbad_pkg::BANK_HI_END);
      wram_idx  = {bank[0], off};
      io_idx    = io_sub[cbad_pkg::IO_AW-1:0];
      rom_idx   = {bank[6:0], off[14:0]};
      rom_ok    = cfg.cart_present && (rom_idx < {1'b0, cfg.rom_len}) &&
                  ({2'b00, rom_idx} < cbad_pkg::ROM_LIMIT);

      priority if (bank >= cbad_pkg::BANK_WRAM_LO && bank <= cbad_pkg::BANK_WRAM_HI) begin
         region = cbad_pkg::SRC_WRAM;
      end else if (low_banks && off <= cbad_pkg::OFF_MIRROR_END) begin
         region   = cbad_pkg::SRC_WRAM;
         wram_idx = {4'b0000, off[12:0]};
      end else if (low_banks && off >= cbad_pkg::OFF_IO_BEG && off <= cbad_pkg::OFF_IO_END) begin
         region = cbad_pkg::SRC_IO;
      end else if (bank <= cbad_pkg::BANK_ROM_END && off >= cbad_pkg::OFF_ROM_BEG) begin
         region = rom_ok ? cbad_pkg::SRC_ROM : cbad_pkg::SRC_FF;
      end else begin
         region = cbad_pkg::SRC_FF;
      end
   end

   always_comb begin
      last_issue = act_ff && (lane_ff == cur_ff.last_lane);
      pop        = !clr_ff && !q_status.empty && (!act_ff || last_issue);

      // clearing pass: one entry per cycle, I/O wraps inside the same sweep
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == cbad_pkg::CLR_LAST) begin
            clr_in = 1'b0;
         end
      end

      act_in  = act_ff;
      cur_in  = cur_ff;
      lane_in = lane_ff;
      if (pop) begin
         act_in  = 1'b1;
         cur_in  = head;
         lane_in = 2'd0;
      end else if (last_issue) begin
         act_in = 1'b0;
      end else if (act_ff) begin
         cur_in.address = cur_ff.address + 24'd1;
         cur_in.data    = {8'h00, cur_ff.data[15:8]};
         lane_in        = lane_ff + 2'd1;
      end

      // memory ports
      wram_we       = clr_ff || (act_ff && cur_ff.kind == cbad_pkg::OP_WRITE &&
                                 region == cbad_pkg::SRC_WRAM);
      io_we         = clr_ff || (act_ff && cur_ff.kind == cbad_pkg::OP_WRITE &&
                                 region == cbad_pkg::SRC_IO);
      rom_we        = act_ff && cur_ff.kind == cbad_pkg::OP_LOAD &&
                      (cur_ff.address < cbad_pkg::ROM_LIMIT);
      wram_port_idx = clr_ff ? clr_cnt_ff : wram_idx;
      io_addr       = clr_ff ? clr_cnt_ff[cbad_pkg::IO_AW-1:0] : io_idx;
      wram_wdata    = clr_ff ? 8'h00 : cur_ff.data[7:0];
      io_wdata      = clr_ff ? 8'h00 : cur_ff.data[7:0];
      rom_port_idx  = (cur_ff.kind == cbad_pkg::OP_LOAD) ?
                      cur_ff.address[cbad_pkg::ROM_AW-1:0] : rom_idx[cbad_pkg::ROM_AW-1:0];

      cap_in.valid   = act_ff;
      cap_in.is_read = (cur_ff.kind == cbad_pkg::OP_READ);
      cap_in.src     = cap_in.is_read ? region : cbad_pkg::SRC_FF;
      cap_in.lane    = lane_ff;
      cap_in.last    = last_issue;

      // capture: read data for the previous beat is out of the RAMs now
      unique case (cap_ff.src)
         cbad_pkg::SRC_WRAM: rd_byte = wram_rdata;
         cbad_pkg::SRC_IO:   rd_byte = io_rdata;
         cbad_pkg::SRC_ROM:  rd_byte = rom_rdata;
         default:            rd_byte = cbad_pkg::OPEN_BUS;
      endcase
      acc_in = acc_ff;
      if (cap_ff.valid) begin
         acc_in = ((cap_ff.lane == 2'd0) ? 24'h000000 : acc_ff) |
                  (24'(rd_byte) << {cap_ff.lane, 3'b000});
      end
      rsp_valid_in = cap_ff.valid && cap_ff.last;
      rsp_data_in  = cap_ff.is_read ? acc_in : 24'h000000;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= 1'b1;
         clr_cnt_ff   <= '0;
         act_ff       <= 1'b0;
         cap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         clr_cnt_ff   <= clr_cnt_in;
         act_ff       <= act_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      lane_ff     <= lane_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   cbad_ram #(
      .WIDTH(8),
      .DEPTH(cbad_pkg::WRAM_DEPTH)
   ) u_wram (
      .clock   (clock),
      .wr_en   (wram_we),
      .addr    (wram_port_idx),
      .wr_data (wram_wdata),
      .rd_data (wram_rdata)
   );

   cbad_ram #(
      .WIDTH(8),
      .DEPTH(cbad_pkg::IO_DEPTH)
   ) u_io (
      .clock   (clock),
      .wr_en   (io_we),
      .addr    (io_addr),
      .wr_data (io_wdata),
      .rd_data (io_rdata)
   );

   cbad_ram #(
      .WIDTH(8),
      .DEPTH(cbad_pkg::ROM_DEPTH)
   ) u_rom (
      .clock   (clock),
      .wr_en   (rom_we),
      .addr    (rom_port_idx),
      .wr_data (cur_ff.data[7:0]),
      .rd_data (rom_rdata)
   );

   assign clearing      = clr_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

// File: tb/testbench.sv
// testbench: self-checking bench for console_bus_address_decoder.
// Predicts every response from its own map of work RAM, I/O and cartridge ROM.
// Depends on cbad_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module testbench;
   import cbad_pkg::*;

   // request codes the package leaves unnamed; they must answer zero
   localparam logic [2:0] REQ_UNUSED6 = 3'd6;
   localparam logic [2:0] REQ_UNUSED7 = 3'd7;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned HISTORY_DEPTH = 48;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_type;
   logic [23:0] req_address;
   logic [15:0] req_write_data;
   logic        rsp_valid;
   logic [23:0] rsp_read_data;
   logic        csr_write_enable;
   logic        csr_index;
   logic [20:0] csr_write_data;

   console_bus_address_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_read_data    (rsp_read_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // memory map as the bench sees it
   bit [7:0]    wram_bytes [WRAM_DEPTH];
   bit [7:0]    io_bytes [IO_DEPTH];
   bit [7:0]    rom_bytes [int unsigned];
   int unsigned rom_loaded_index [$];
   bit          cart_inserted;
   logic [20:0] rom_valid_bytes;

   logic [23:0] pending_read_data [$];
   logic [23:0] written_addr [$];
   int          mismatch_count;
   int          sender_gap_max;

   function automatic src_type map_address(input logic [23:0] a, output int unsigned idx);
      logic [7:0]  bank;
      logic [15:0] off;
      logic        low_bank;
      bank = a[23:16];
      off = a[15:0];
      low_bank = (bank <= BANK_LOW_END) || (bank >= BANK_HI_BEG && bank <= BANK_HI_END);
      idx = 0;
      if (bank == BANK_WRAM_LO || bank == BANK_WRAM_HI) begin
         idx = 32'({bank[0], off});
         return SRC_WRAM;
      end
      if (low_bank && off <= OFF_MIRROR_END) begin
         idx = 32'(off);
         return SRC_WRAM;
      end
      if (low_bank && off >= OFF_IO_BEG && off <= OFF_IO_END) begin
         idx = 32'(off - OFF_IO_BEG);
         return SRC_IO;
      end
      if (bank <= BANK_ROM_END && off >= OFF_ROM_BEG) begin
         idx = 32'({bank, off[14:0]});
         return SRC_ROM;
      end
      return SRC_FF;
   endfunction

   function automatic bit rom_visible(input int unsigned idx);
      return cart_inserted && idx < 32'(rom_valid_bytes) && idx < ROM_DEPTH;
   endfunction

   function automatic logic [7:0] fetch_byte(input logic [23:0] a);
      int unsigned idx;
      src_type     src;
      src = map_address(a, idx);
      case (src)
         SRC_WRAM: return wram_bytes[idx];
         SRC_IO:   return io_bytes[idx];
         SRC_ROM:  if (rom_visible(idx)) return rom_bytes[idx];
         default:  ;
      endcase
      return OPEN_BUS;
   endfunction

   function automatic void store_byte(input logic [23:0] a, input logic [7:0] value);
      int unsigned idx;
      src_type     src;
      src = map_address(a, idx);
      if (src == SRC_WRAM)
         wram_bytes[idx] = value;
      else if (src == SRC_IO)
         io_bytes[idx] = value;
   endfunction

   // applies one request to the map and returns the read data it produces
   function automatic logic [23:0] serve_request(input logic [2:0] kind, input logic [23:0] a,
                                                 input logic [15:0] d);
      logic [23:0] a1;
      logic [23:0] a2;
      logic [23:0] result;
      a1 = a + 24'd1;
      a2 = a + 24'd2;
      result = '0;
      case (kind)
         REQ_READ8:   result = {16'h0000, fetch_byte(a)};
         REQ_WRITE8:  store_byte(a, d[7:0]);
         REQ_READ16:  result = {8'h00, fetch_byte(a1), fetch_byte(a)};
         REQ_WRITE16: begin
            store_byte(a, d[7:0]);
            store_byte(a1, d[15:8]);
         end
         REQ_READ24:  result = {fetch_byte(a2), fetch_byte(a1), fetch_byte(a)};
         REQ_LOAD: begin
            if (a < ROM_LIMIT) begin
               if (!rom_bytes.exists(32'(a)))
                  rom_loaded_index.push_back(32'(a));
               rom_bytes[32'(a)] = d[7:0];
            end
         end
         default: ;
      endcase
      return result;
   endfunction

   // false when a read would return a ROM byte never loaded since reset
   function automatic bit rom_read_ok(input logic [23:0] a, input int nbytes);
      int unsigned idx;
      for (int k = 0; k < nbytes; k++) begin
         if (map_address(a + 24'(k), idx) == SRC_ROM && rom_visible(idx) &&
             !rom_bytes.exists(idx))
            return 0;
      end
      return 1;
   endfunction

   always @(posedge clock) begin : response_check
      logic [23:0] want;
      if (!reset && rsp_valid) begin
         if (pending_read_data.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("response with nothing outstanding: read_data=%h", rsp_read_data);
         end else begin
            want = pending_read_data.pop_front();
            if (rsp_read_data !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("read_data mismatch: expected %h actual %h", want, rsp_read_data);
            end
         end
      end
   end

   task automatic pause_sender(input int unsigned cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // start stays high after the beat so back-to-back items need no extra assignment
   task automatic send_request(input logic [2:0] kind, input logic [23:0] a,
                               input logic [15:0] d);
      pause_sender($urandom_range(0, sender_gap_max));
      req_type <= kind;
      req_address <= a;
      req_write_data <= d;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_read_data.push_back(serve_request(kind, a, d));
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_read_data.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input bit cart, input logic [20:0] size);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_CART_PRESENT;
      csr_write_data <= {20'h00000, cart};
      @(posedge clock);
      cart_inserted = cart;
      csr_index <= CSR_ROM_SIZE;
      csr_write_data <= size;
      @(posedge clock);
      rom_valid_bytes = size;
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [23:0] pick_address();
      logic [7:0]  bank;
      logic [15:0] off;
      bank = 8'($urandom);
      off = 16'($urandom);
      case ($urandom_range(0, 6))
         0: bank = 8'($urandom_range(BANK_WRAM_LO, BANK_WRAM_HI));
         1: begin
            bank = {1'($urandom), 1'b0, 6'($urandom)};
            off = 16'($urandom_range(0, OFF_MIRROR_END));
         end
         2: begin
            bank = {1'($urandom), 1'b0, 6'($urandom)};
            off = 16'($urandom_range(OFF_IO_BEG, OFF_IO_END));
         end
         3: begin
            bank = 8'($urandom_range(0, BANK_ROM_END));
            off = 16'($urandom_range(OFF_ROM_BEG, 16'hFFFF));
         end
         4: begin
            case ($urandom_range(0, 8))
               0: off = 16'h0000;
               1: off = OFF_MIRROR_END;
               2: off = OFF_IO_BEG;
               3: off = OFF_IO_END;
               4: off = OFF_IO_END + 16'd1;
               5: off = OFF_ROM_BEG - 16'd1;
               6: off = OFF_ROM_BEG;
               7: off = 16'hFFFE;
               default: off = 16'hFFFF;
            endcase
         end
         5: begin
            case ($urandom_range(0, 9))
               0: bank = 8'h00;
               1: bank = BANK_LOW_END;
               2: bank = BANK_LOW_END + 8'd1;
               3: bank = BANK_ROM_END;
               4: bank = BANK_WRAM_LO;
               5: bank = BANK_WRAM_HI;
               6: bank = BANK_HI_BEG;
               7: bank = BANK_HI_END;
               8: bank = BANK_HI_END + 8'd1;
               default: bank = 8'hFF;
            endcase
         end
         default: ;
      endcase
      return {bank, off};
   endfunction

   task automatic random_request(output logic [2:0] kind, output logic [23:0] a,
                                 output logic [15:0] d);
      int unsigned pick;
      int unsigned idx;
      int          nbytes;
      pick = $urandom_range(0, 99);
      d = 16'($urandom);
      a = pick_address();
      if (pick < 30) begin
         kind = (pick < 15) ? REQ_WRITE8 : REQ_WRITE16;
         if ($urandom_range(0, 2) == 0 && written_addr.size() > 0)
            a = written_addr[$urandom_range(0, written_addr.size() - 1)];
      end else if (pick < 80) begin
         case ($urandom_range(0, 2))
            0: kind = REQ_READ8;
            1: kind = REQ_READ16;
            default: kind = REQ_READ24;
         endcase
         nbytes = (kind == REQ_READ8) ? 1 : (kind == REQ_READ16) ? 2 : 3;
         // mostly read back what was written or loaded, so the data means something
         if (pick < 50 && written_addr.size() > 0) begin
            a = written_addr[$urandom_range(0, written_addr.size() - 1)] -
                24'($urandom_range(0, 2));
         end else if (pick < 65 && rom_loaded_index.size() > 0) begin
            idx = rom_loaded_index[$urandom_range(0, rom_loaded_index.size() - 1)];
            a = {3'b000, idx[19:15], 1'b1, idx[14:0]};
         end
         if (!rom_read_ok(a, nbytes)) begin
            if (rom_read_ok(a, 1))
               kind = REQ_READ8;
            else
               a = {BANK_WRAM_LO, 16'($urandom)};
         end
      end else if (pick < 95) begin
         kind = REQ_LOAD;
         case ($urandom_range(0, 4))
            0: idx = $urandom_range(0, 63);
            1: idx = 32'h7FE0 + $urandom_range(0, 63);
            2: idx = ROM_DEPTH - 64 + $urandom_range(0, 63);
            3: idx = $urandom_range(0, ROM_DEPTH - 1);
            default: idx = $urandom & 32'hFFFFFF;
         endcase
         a = idx[23:0];
      end else begin
         kind = pick[0] ? REQ_UNUSED6 : REQ_UNUSED7;
      end
   endtask

   // reset contents: RAM and I/O read zero, holes read open bus
   task automatic test_reset_state();
      send_request(REQ_READ8, 24'h7E0000, 16'h0000);
      send_request(REQ_READ24, 24'h7FFFFE, 16'h0000);
      send_request(REQ_READ16, 24'h3F1FFF, 16'h0000);
      send_request(REQ_READ16, 24'hBF5FFF, 16'h0000);
      send_request(REQ_READ8, 24'h406000, 16'h0000);
      send_request(REQ_UNUSED6, 24'hFFFFFF, 16'hFFFF);
      wait_idle();
   endtask

   task automatic test_rom_access();
      set_config(1'b1, 21'(ROM_DEPTH));
      send_request(REQ_LOAD, 24'h000000, 16'h00A5);
      send_request(REQ_LOAD, 24'h000001, 16'hFF5A);
      send_request(REQ_LOAD, 24'h000002, 16'h12C3);
      send_request(REQ_LOAD, 24'h007FFF, 16'h0081);
      send_request(REQ_LOAD, 24'h0FFFFF, 16'h007E);
      // loads past the ROM end are dropped
      send_request(REQ_LOAD, 24'h100000, 16'h0011);
      send_request(REQ_LOAD, 24'hFFFFFF, 16'h0022);
      send_request(REQ_READ24, 24'h008000, 16'h0000);
      // crosses from ROM into the low RAM mirror of the next bank
      send_request(REQ_READ16, 24'h00FFFF, 16'h0000);
      send_request(REQ_READ8, 24'h1FFFFF, 16'h0000);
      send_request(REQ_WRITE8, 24'h008000, 16'hFFFF);
      send_request(REQ_READ8, 24'h008000, 16'h0000);
      send_request(REQ_READ8, 24'h208000, 16'h0000);
      wait_idle();
      set_config(1'b1, 21'd2);
      send_request(REQ_READ24, 24'h008000, 16'h0000);
      wait_idle();
      set_config(1'b0, 21'(ROM_DEPTH));
      send_request(REQ_READ8, 24'h008000, 16'h0000);
      wait_idle();
   endtask

   // multi-byte accesses wrap at the top of the 24-bit space; mirrors alias RAM and I/O
   task automatic test_wrap_and_alias();
      send_request(REQ_WRITE16, 24'hFFFFFF, 16'hBEEF);
      send_request(REQ_READ24, 24'h7FFFFF, 16'h0000);
      send_request(REQ_WRITE16, 24'h005FFF, 16'h1234);
      send_request(REQ_READ16, 24'hBF5FFF, 16'h0000);
      wait_idle();
   endtask

   task automatic test_random_traffic(input bit cart, input logic [20:0] size,
                                      input int count, input int gap_max);
      logic [2:0]  kind;
      logic [23:0] a;
      logic [15:0] d;
      set_config(cart, size);
      sender_gap_max = gap_max;
      repeat (count) begin
         random_request(kind, a, d);
         send_request(kind, a, d);
         if (kind == REQ_WRITE8 || kind == REQ_WRITE16) begin
            written_addr.push_back(a);
            if (written_addr.size() > HISTORY_DEPTH)
               void'(written_addr.pop_front());
         end
      end
      // sender holds off until every beat has been answered
      wait_idle();
   endtask

   initial begin
      logic [20:0] mid_size;
      mismatch_count = 0;
      sender_gap_max = 8;
      cart_inserted = 1'b0;
      rom_valid_bytes = '0;
      reset <= 1'b1;
      start <= 1'b0;
      req_type <= REQ_READ8;
      req_address <= '0;
      req_write_data <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_CART_PRESENT;
      csr_write_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_rom_access();
      test_wrap_and_alias();
      mid_size = 21'($urandom_range(1, ROM_DEPTH - 1));
      test_random_traffic(1'b1, 21'(ROM_DEPTH), 155, 8);
      test_random_traffic(1'b1, 21'h008004, 155, 0);
      test_random_traffic(1'b0, 21'(ROM_DEPTH), 155, 8);
      test_random_traffic(1'b1, mid_size, 155, 4);
      test_random_traffic(1'b1, 21'd0, 155, 8);
      test_random_traffic(1'b1, 21'(ROM_DEPTH), 155, 0);

      if (mismatch_count == 0 && pending_read_data.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   // covers the RAM clearing pass after reset with wide margin
   initial begin
      #5_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
